@@ src/rmc_pkg.sv @@
// ----------------------------------------------------------------------------
// RMC parser package
// Shared character codes, field numbers, status codes, pipeline types and
// the reciprocal constants used for division by 3 and 100.
// ----------------------------------------------------------------------------
package rmc_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_VALID    = 2'd0,
    STAT_VOID     = 2'd1,
    STAT_NOT_RMC  = 2'd2,
    STAT_TOO_LONG = 2'd3
  } rmc_status_e;

  // Character codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_W      = 8'h57;

  // Field numbers inside a sentence
  localparam logic [3:0] FLD_HDR    = 4'd0;
  localparam logic [3:0] FLD_TIME   = 4'd1;
  localparam logic [3:0] FLD_STATUS = 4'd2;
  localparam logic [3:0] FLD_LAT    = 4'd3;
  localparam logic [3:0] FLD_NS     = 4'd4;
  localparam logic [3:0] FLD_LON    = 4'd5;
  localparam logic [3:0] FLD_EW     = 4'd6;
  localparam logic [3:0] FLD_SPEED  = 4'd7;
  localparam logic [3:0] FLD_DATE   = 4'd9;
  localparam logic [3:0] FLD_LAST   = 4'd15;

  localparam logic [7:0]  HDR_LEN         = 8'd5;
  localparam logic [2:0]  SPEED_FRAC_DIG  = 3'd3;
  localparam logic [19:0] NUM_SAT         = 20'd999999;
  localparam logic [13:0] LAT_WHOLE_MAX   = 14'd16383;
  localparam logic [14:0] LON_WHOLE_MAX   = 15'd32767;
  localparam logic [32:0] LAT_MAG_MAX     = 33'd900000000;
  localparam logic [32:0] LON_MAG_MAX     = 33'd1800000000;
  localparam logic [31:0] DEG_E7          = 32'd10000000;
  localparam logic [27:0] KMH_NUM         = 28'd185;

  // floor(x/100) for x < 2**15: (x * DIV100_W_M) >> DIV100_W_SH
  localparam logic [15:0] DIV100_W_M  = 16'd41944;
  localparam int          DIV100_W_SH = 22;
  // floor(x/100) for x < 2**28
  localparam logic [28:0] DIV100_S_M  = 29'd343597384;
  localparam int          DIV100_S_SH = 35;
  // floor(x/3) for x < 2**26
  localparam logic [25:0] DIV3_M      = 26'd44739243;
  localparam int          DIV3_SH     = 27;

  typedef struct packed {
    logic [14:0] whole;   // ddmm or dddmm
    logic [16:0] frac;    // minute fraction digits, padded
    logic        neg;
    logic [8:0]  deg;
    logic [6:0]  minute;
    logic [31:0] deg_e7;
    logic [23:0] m;
    logic [25:0] x;
    logic [23:0] q;
  } rmc_coord_t;

  typedef struct packed {
    rmc_status_e status;
    rmc_coord_t  lat;
    rmc_coord_t  lon;
    logic [19:0] spd_int;
    logic [9:0]  spd_frac;
    logic [19:0] spd;
    logic [27:0] spd185;
    logic [20:0] spd_out;
    logic [19:0] utc_time;
    logic [19:0] utc_date;
  } rmc_pipe_t;

  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h47;  // G
      3'd1:    ch = 8'h50;  // P
      3'd2:    ch = 8'h52;  // R
      3'd3:    ch = 8'h4D;  // M
      3'd4:    ch = 8'h43;  // C
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic int unsigned pow10(input int k);
    int unsigned r;
    r = 1;
    for (int i = 0; i < k; i++) r = r * 10;
    return r;
  endfunction

endpackage

@@ src/nmea_rmc_parser_core.sv @@
// ----------------------------------------------------------------------------
// NMEA RMC parser core
// Byte-serial parser for RMC sentences, one fix record per sentence.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                     payload
//  --------  ---  ----------------------------  -------------------------------
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata[7:0]   rx_byte
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata[125:0] fix record
//  cfg       in   cfg_valid_i / cfg_ready_o      cfg_data_i   speed_in_kmh
//
//  One byte beat is accepted every cycle unless the pipe is full. A byte is
//  parsed in the cycle it is taken; a newline launches the fix record into a
//  six-stage conversion pipe (divide by 100, minute scaling, divide by 3, one
//  constant multiply per stage), then through the output register to m_axis.
//  Reset clears the parser and all valid bits; cfg is always ready.
//  A stall on m_axis fills the pipe bubble by bubble; s_axis tready drops
//  only when every stage holds a record.
//
module nmea_rmc_parser_core #(
  parameter int MAX_SENTENCE_LEN   = 128,
  parameter int MINUTE_FRAC_DIGITS = 5
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // [7:0] rx_byte
  input  logic [7:0]   s_axis_tdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [1:0] fix_status, [32:2] latitude_e7, [64:33] longitude_e7,
  // [85:65] speed_milli, [105:86] utc_time, [125:106] utc_date, [127:126] zero
  output logic [127:0] m_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_data_i
);
  import rmc_pkg::*;

  localparam int FRAC_D = (MINUTE_FRAC_DIGITS < 1) ? 1 :
                          ((MINUTE_FRAC_DIGITS > 5) ? 5 : MINUTE_FRAC_DIGITS);
  localparam logic [2:0]  FRAC_LIM   = 3'(FRAC_D);
  localparam logic [23:0] FRAC_SCALE = 24'(pow10(FRAC_D));
  // 1e7 / (60 * 10**D) == MIN_K / 3
  localparam logic [25:0] MIN_K      = 26'(5 * pow10(5 - FRAC_D));
  localparam logic [7:0]  MAX_LEN    = 8'(MAX_SENTENCE_LEN);
  localparam int          PIPE_DEPTH = 6;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic kmh_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmh_q <= 1'b0;
    end else if (cfg_valid_i) begin
      kmh_q <= cfg_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // Parser state
  // --------------------------------------------------------------------------
  logic        in_sent_q, in_sent_d;
  logic [3:0]  field_q, field_d;
  logic [7:0]  char_cnt_q, char_cnt_d;
  logic        hdr_q, hdr_d;
  logic        stat_act_q, stat_act_d;
  logic [19:0] acc_q, acc_d;
  logic [16:0] facc_q, facc_d;
  logic [2:0]  fcnt_q, fcnt_d;
  logic        after_pt_q, after_pt_d;
  logic [13:0] latw_q, latw_d;
  logic [16:0] latf_q, latf_d;
  logic [14:0] lonw_q, lonw_d;
  logic [16:0] lonf_q, lonf_d;
  logic        south_q, south_d;
  logic        west_q, west_d;
  logic [19:0] spdw_q, spdw_d;
  logic [9:0]  spdf_q, spdf_d;
  logic [19:0] time_q, time_d;
  logic [19:0] date_q, date_d;

  // Values as they stand once the current field is closed
  logic        hdr_c;
  logic [13:0] latw_c;
  logic [16:0] latf_c;
  logic [14:0] lonw_c;
  logic [16:0] lonf_c;
  logic [19:0] spdw_c;
  logic [9:0]  spdf_c;
  logic [19:0] time_c;
  logic [19:0] date_c;
  logic [2:0]  frac_lim;
  logic [2:0]  pad_k;
  logic [16:0] f_pad;

  logic        in_fire;
  logic        emit;
  rmc_status_e emit_status;
  logic        is_digit;
  logic        first_ch;
  logic [23:0] acc_x10;

  assign in_fire  = s_axis_tvalid & s_axis_tready;
  assign is_digit = (s_axis_tdata >= CH_ZERO) && (s_axis_tdata <= CH_NINE);
  assign first_ch = (acc_q == '0);
  assign acc_x10  = 24'(acc_q) * 24'd10 + 24'(s_axis_tdata[3:0]);

  // Close the open field: pad the fraction to its digit count and latch it
  always_comb begin
    frac_lim = (field_q == FLD_SPEED) ? SPEED_FRAC_DIG : FRAC_LIM;
    pad_k    = (frac_lim > fcnt_q) ? 3'(frac_lim - fcnt_q) : 3'd0;
    case (pad_k)
      3'd0:    f_pad = facc_q;
      3'd1:    f_pad = 17'(facc_q * 17'd10);
      3'd2:    f_pad = 17'(facc_q * 17'd100);
      3'd3:    f_pad = 17'(facc_q * 17'd1000);
      3'd4:    f_pad = 17'(facc_q * 17'd10000);
      default: f_pad = 17'(facc_q * 17'd100000);
    endcase

    hdr_c  = hdr_q & ~((field_q == FLD_HDR) && (char_cnt_q != HDR_LEN));
    time_c = (field_q == FLD_TIME) ? acc_q : time_q;
    date_c = (field_q == FLD_DATE) ? acc_q : date_q;
    latw_c = latw_q;
    latf_c = latf_q;
    lonw_c = lonw_q;
    lonf_c = lonf_q;
    spdw_c = spdw_q;
    spdf_c = spdf_q;
    if (field_q == FLD_LAT) begin
      latw_c = (acc_q > 20'(LAT_WHOLE_MAX)) ? LAT_WHOLE_MAX : acc_q[13:0];
      latf_c = f_pad;
    end
    if (field_q == FLD_LON) begin
      lonw_c = (acc_q > 20'(LON_WHOLE_MAX)) ? LON_WHOLE_MAX : acc_q[14:0];
      lonf_c = f_pad;
    end
    if (field_q == FLD_SPEED) begin
      spdw_c = acc_q;
      spdf_c = f_pad[9:0];
    end
  end

  always_comb begin
    in_sent_d   = in_sent_q;
    field_d     = field_q;
    char_cnt_d  = char_cnt_q;
    hdr_d       = hdr_q;
    stat_act_d  = stat_act_q;
    acc_d       = acc_q;
    facc_d      = facc_q;
    fcnt_d      = fcnt_q;
    after_pt_d  = after_pt_q;
    latw_d      = latw_q;
    latf_d      = latf_q;
    lonw_d      = lonw_q;
    lonf_d      = lonf_q;
    south_d     = south_q;
    west_d      = west_q;
    spdw_d      = spdw_q;
    spdf_d      = spdf_q;
    time_d      = time_q;
    date_d      = date_q;
    emit        = 1'b0;
    emit_status = STAT_VOID;

    if (in_fire) begin
      if (s_axis_tdata == CH_DOLLAR) begin
        // Start (or restart) a sentence
        in_sent_d  = 1'b1;
        field_d    = '0;
        char_cnt_d = '0;
        hdr_d      = 1'b1;
        stat_act_d = 1'b0;
        acc_d      = '0;
        facc_d     = '0;
        fcnt_d     = '0;
        after_pt_d = 1'b0;
        latw_d     = '0;
        latf_d     = '0;
        lonw_d     = '0;
        lonf_d     = '0;
        south_d    = 1'b0;
        west_d     = 1'b0;
        spdw_d     = '0;
        spdf_d     = '0;
        time_d     = '0;
        date_d     = '0;
      end else if (in_sent_q && (s_axis_tdata == CH_LF)) begin
        // End of sentence: emit one record
        in_sent_d = 1'b0;
        emit      = 1'b1;
        if (char_cnt_q >= MAX_LEN) begin
          emit_status = STAT_TOO_LONG;
        end else if (!hdr_c) begin
          emit_status = STAT_NOT_RMC;
        end else begin
          emit_status = stat_act_q ? STAT_VALID : STAT_VOID;
        end
      end else if (in_sent_q && (s_axis_tdata != CH_CR) && (char_cnt_q < MAX_LEN)) begin
        char_cnt_d = char_cnt_q + 8'd1;
        if (s_axis_tdata == CH_COMMA) begin
          hdr_d      = hdr_c;
          time_d     = time_c;
          date_d     = date_c;
          latw_d     = latw_c;
          latf_d     = latf_c;
          lonw_d     = lonw_c;
          lonf_d     = lonf_c;
          spdw_d     = spdw_c;
          spdf_d     = spdf_c;
          acc_d      = '0;
          facc_d     = '0;
          fcnt_d     = '0;
          after_pt_d = 1'b0;
          if (field_q != FLD_LAST) field_d = field_q + 4'd1;
        end else begin
          case (field_q) inside
            FLD_HDR: begin
              if ((char_cnt_q >= HDR_LEN) || (s_axis_tdata != hdr_char(char_cnt_q[2:0]))) begin
                hdr_d = 1'b0;
              end
            end
            FLD_STATUS, FLD_NS, FLD_EW: begin
              if (field_q == FLD_STATUS) stat_act_d = first_ch && (s_axis_tdata == CH_A);
              if ((field_q == FLD_NS) && first_ch) south_d = (s_axis_tdata == CH_S);
              if ((field_q == FLD_EW) && first_ch) west_d = (s_axis_tdata == CH_W);
              if (acc_q < NUM_SAT) acc_d = acc_q + 20'd1;
            end
            FLD_TIME, FLD_LAT, FLD_LON, FLD_SPEED, FLD_DATE: begin
              if (s_axis_tdata == CH_DOT) begin
                after_pt_d = 1'b1;
              end else if (is_digit) begin
                if (!after_pt_q) begin
                  acc_d = (acc_x10 > 24'(NUM_SAT)) ? NUM_SAT : acc_x10[19:0];
                end else if (fcnt_q < frac_lim) begin
                  facc_d = 17'(facc_q * 17'd10) + 17'(s_axis_tdata[3:0]);
                  fcnt_d = fcnt_q + 3'd1;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sent_q  <= 1'b0;
      field_q    <= '0;
      char_cnt_q <= '0;
      hdr_q      <= 1'b0;
      stat_act_q <= 1'b0;
      acc_q      <= '0;
      facc_q     <= '0;
      fcnt_q     <= '0;
      after_pt_q <= 1'b0;
      latw_q     <= '0;
      latf_q     <= '0;
      lonw_q     <= '0;
      lonf_q     <= '0;
      south_q    <= 1'b0;
      west_q     <= 1'b0;
      spdw_q     <= '0;
      spdf_q     <= '0;
      time_q     <= '0;
      date_q     <= '0;
    end else begin
      in_sent_q  <= in_sent_d;
      field_q    <= field_d;
      char_cnt_q <= char_cnt_d;
      hdr_q      <= hdr_d;
      stat_act_q <= stat_act_d;
      acc_q      <= acc_d;
      facc_q     <= facc_d;
      fcnt_q     <= fcnt_d;
      after_pt_q <= after_pt_d;
      latw_q     <= latw_d;
      latf_q     <= latf_d;
      lonw_q     <= lonw_d;
      lonf_q     <= lonf_d;
      south_q    <= south_d;
      west_q     <= west_d;
      spdw_q     <= spdw_d;
      spdf_q     <= spdf_d;
      time_q     <= time_d;
      date_q     <= date_d;
    end
  end

  // --------------------------------------------------------------------------
  // Conversion pipe: one constant multiply per stage
  // --------------------------------------------------------------------------
  // deg = whole / 100
  function automatic rmc_coord_t coord_div100(input rmc_coord_t c);
    rmc_coord_t r;
    logic [30:0] p;
    r     = c;
    p     = 31'(c.whole) * 31'(DIV100_W_M);
    r.deg = 9'(p >> DIV100_W_SH);
    return r;
  endfunction

  // minute = whole % 100, degrees scaled to 1e-7
  function automatic rmc_coord_t coord_split(input rmc_coord_t c);
    rmc_coord_t r;
    r        = c;
    r.minute = 7'(c.whole - 15'(c.deg * 9'd100));
    r.deg_e7 = 32'(c.deg) * DEG_E7;
    return r;
  endfunction

  // minutes in units of 10**-D
  function automatic rmc_coord_t coord_minutes(input rmc_coord_t c);
    rmc_coord_t r;
    r   = c;
    r.m = 24'(24'(c.minute) * FRAC_SCALE) + 24'(c.frac);
    return r;
  endfunction

  function automatic rmc_coord_t coord_scale(input rmc_coord_t c);
    rmc_coord_t r;
    r   = c;
    r.x = 26'(26'(c.m) * MIN_K);
    return r;
  endfunction

  // q = x / 3
  function automatic rmc_coord_t coord_div3(input rmc_coord_t c);
    rmc_coord_t r;
    logic [51:0] p;
    r   = c;
    p   = 52'(c.x) * 52'(DIV3_M);
    r.q = 24'(p >> DIV3_SH);
    return r;
  endfunction

  rmc_pipe_t              pipe_q [PIPE_DEPTH];
  rmc_pipe_t              pipe_d [PIPE_DEPTH];
  logic [PIPE_DEPTH:0]    vld_q;
  logic [PIPE_DEPTH:0]    adv;
  logic [29:0]            spd_sum;
  logic [56:0]            spd_div;

  // Stage k loads when it is empty or its record moves on
  always_comb begin
    adv[PIPE_DEPTH] = ~vld_q[PIPE_DEPTH] | m_axis_tready;
    for (int k = PIPE_DEPTH - 1; k >= 0; k--) begin
      adv[k] = ~vld_q[k] | adv[k + 1];
    end
  end

  assign s_axis_tready = adv[0];

  always_comb begin
    // Stage 0: snapshot of the closed sentence
    pipe_d[0]            = '0;
    pipe_d[0].status     = emit_status;
    pipe_d[0].lat.whole  = 15'(latw_c);
    pipe_d[0].lat.frac   = latf_c;
    pipe_d[0].lat.neg    = south_q;
    pipe_d[0].lon.whole  = lonw_c;
    pipe_d[0].lon.frac   = lonf_c;
    pipe_d[0].lon.neg    = west_q;
    pipe_d[0].spd_int    = spdw_c;
    pipe_d[0].spd_frac   = spdf_c;
    pipe_d[0].utc_time   = time_c;
    pipe_d[0].utc_date   = date_c;

    pipe_d[1]     = pipe_q[0];
    pipe_d[1].lat = coord_div100(pipe_q[0].lat);
    pipe_d[1].lon = coord_div100(pipe_q[0].lon);
    spd_sum       = 30'(pipe_q[0].spd_int) * 30'd1000 + 30'(pipe_q[0].spd_frac);
    pipe_d[1].spd = (spd_sum > 30'(NUM_SAT)) ? NUM_SAT : spd_sum[19:0];

    pipe_d[2]        = pipe_q[1];
    pipe_d[2].lat    = coord_split(pipe_q[1].lat);
    pipe_d[2].lon    = coord_split(pipe_q[1].lon);
    pipe_d[2].spd185 = 28'(pipe_q[1].spd) * KMH_NUM;

    pipe_d[3]         = pipe_q[2];
    pipe_d[3].lat     = coord_minutes(pipe_q[2].lat);
    pipe_d[3].lon     = coord_minutes(pipe_q[2].lon);
    spd_div           = 57'(pipe_q[2].spd185) * 57'(DIV100_S_M);
    pipe_d[3].spd_out = kmh_q ? 21'(spd_div >> DIV100_S_SH) : 21'(pipe_q[2].spd);

    pipe_d[4]     = pipe_q[3];
    pipe_d[4].lat = coord_scale(pipe_q[3].lat);
    pipe_d[4].lon = coord_scale(pipe_q[3].lon);

    pipe_d[5]     = pipe_q[4];
    pipe_d[5].lat = coord_div3(pipe_q[4].lat);
    pipe_d[5].lon = coord_div3(pipe_q[4].lon);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_fire & emit;
      for (int k = 1; k <= PIPE_DEPTH; k++) begin
        if (adv[k]) vld_q[k] <= vld_q[k - 1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < PIPE_DEPTH; k++) begin
      if (adv[k]) pipe_q[k] <= pipe_d[k];
    end
  end

  // --------------------------------------------------------------------------
  // Output register: sum, saturate, apply hemisphere sign
  // --------------------------------------------------------------------------
  rmc_status_e out_status_q;
  logic [30:0] out_lat_q, out_lat_d;
  logic [31:0] out_lon_q, out_lon_d;
  logic [20:0] out_spd_q, out_spd_d;
  logic [19:0] out_time_q, out_time_d;
  logic [19:0] out_date_q, out_date_d;
  logic [32:0] lat_mag, lon_mag;
  logic [32:0] lat_sat, lon_sat;

  always_comb begin
    lat_mag    = 33'(pipe_q[5].lat.deg_e7) + 33'(pipe_q[5].lat.q);
    lon_mag    = 33'(pipe_q[5].lon.deg_e7) + 33'(pipe_q[5].lon.q);
    lat_sat    = (lat_mag > LAT_MAG_MAX) ? LAT_MAG_MAX : lat_mag;
    lon_sat    = (lon_mag > LON_MAG_MAX) ? LON_MAG_MAX : lon_mag;
    out_lat_d  = 31'(pipe_q[5].lat.neg ? (33'd0 - lat_sat) : lat_sat);
    out_lon_d  = 32'(pipe_q[5].lon.neg ? (33'd0 - lon_sat) : lon_sat);
    out_spd_d  = pipe_q[5].spd_out;
    out_time_d = pipe_q[5].utc_time;
    out_date_d = pipe_q[5].utc_date;
    // Drop the payload of anything but a valid fix
    if (pipe_q[5].status != STAT_VALID) begin
      out_lat_d  = '0;
      out_lon_d  = '0;
      out_spd_d  = '0;
      out_time_d = '0;
      out_date_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[PIPE_DEPTH]) begin
      out_status_q <= pipe_q[5].status;
      out_lat_q    <= out_lat_d;
      out_lon_q    <= out_lon_d;
      out_spd_q    <= out_spd_d;
      out_time_q   <= out_time_d;
      out_date_q   <= out_date_d;
    end
  end

  assign m_axis_tvalid = vld_q[PIPE_DEPTH];
  assign m_axis_tdata  = {2'b00, out_date_q, out_time_q, out_spd_q,
                          out_lon_q, out_lat_q, out_status_q};

endmodule

@@ src/rmc_core_checker.sv @@
// ----------------------------------------------------------------------------
// RMC parser port checker
// Watches the result channel of the parser core for stall, payload and range rules.
// ----------------------------------------------------------------------------
module rmc_core_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready
);
  import rmc_pkg::*;

  logic unused_in;
  assign unused_in = s_axis_tvalid & s_axis_tready;

  // Hold a stalled record
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Anything but a valid fix carries an all-zero payload
  a_void_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[1:0] != STAT_VALID) |-> m_axis_tdata[127:2] == '0)
    else $error("non-valid record with payload");

  a_lat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[32:2]) >= -31'sd900000000) &&
                      ($signed(m_axis_tdata[32:2]) <= 31'sd900000000))
    else $error("latitude out of range");

  a_spd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[85:65] <= 21'd1849998)
    else $error("speed out of range");

endmodule

bind nmea_rmc_parser_core rmc_core_checker u_rmc_core_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
